[hw/rtl/rxo_pkg.sv]
// Shared types, constants and helper functions for the rolling XOR obfuscator.
package rxo_pkg;

  // Store geometry
  localparam int unsigned STRING_DEPTH = 1024;
  localparam int unsigned STR_AW       = $clog2(STRING_DEPTH);

  // Field widths
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd2;

  // Character filter constants
  localparam logic [BYTE_W-1:0] CHAR_LIMIT   = 8'd127;
  localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CHAR_PERIOD  = 8'h2E;

  // Op queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2
  } op_kind_e;

  // One classified operation: value is the string byte, the seeded key or the data byte;
  // flag is the first-position parity or the last-byte mark.
  typedef struct packed {
    op_kind_e             kind;
    logic [ADDR_W-1:0]    addr;
    logic [BYTE_W-1:0]    value;
    logic                 flag;
  } op_t;

  // Replace non-ASCII and percent characters by a period
  function automatic logic [BYTE_W-1:0] filter_char(input logic [BYTE_W-1:0] c);
    if ((c > CHAR_LIMIT) || (c == CHAR_PERCENT)) begin
      return CHAR_PERIOD;
    end
    return c;
  endfunction

endpackage

[hw/rtl/rxo_front.sv]
// Front end: challenge register, item classification and key seeding.
module rxo_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rxo_pkg::WORD_W-1:0] cfg_wdata_i,
  input  logic [rxo_pkg::FUNC_W-1:0] func_i,
  input  logic [rxo_pkg::ADDR_W-1:0] string_addr_i,
  input  logic [rxo_pkg::BYTE_W-1:0] string_byte_i,
  input  logic [rxo_pkg::WORD_W-1:0] seed_a_i,
  input  logic [rxo_pkg::WORD_W-1:0] seed_b_i,
  input  logic                       first_position_odd_i,
  input  logic [rxo_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       is_last_i,
  input  logic                       accept_i,
  output logic                       op_push_o,
  output rxo_pkg::op_t               op_o
);
  import rxo_pkg::*;

  logic [WORD_W-1:0] challenge_q;
  logic [WORD_W-1:0] seed_word;
  logic              op_keep;

  // Challenge register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      challenge_q <= '0;
    end else if (cfg_we_i) begin
      challenge_q <= cfg_wdata_i;
    end
  end

  assign seed_word = challenge_q ^ seed_a_i ^ seed_b_i;

  // Classify the item; unused codes are dropped here
  always_comb begin
    op_keep     = 1'b1;
    op_o.kind   = OP_DATA;
    op_o.addr   = string_addr_i;
    op_o.value  = data_byte_i;
    op_o.flag   = is_last_i;
    case (func_i)
      FUNC_LOAD: begin
        op_o.kind  = OP_LOAD;
        op_o.value = string_byte_i;
        op_o.flag  = 1'b0;
      end
      FUNC_START: begin
        op_o.kind  = OP_START;
        op_o.value = seed_word[BYTE_W-1:0];
        op_o.flag  = first_position_odd_i;
      end
      FUNC_DATA: begin
        op_o.kind = OP_DATA;
      end
      default: begin
        op_keep = 1'b0;
      end
    endcase
  end

  assign op_push_o = accept_i && op_keep;

endmodule

[hw/rtl/rxo_fifo.sv]
// Small op queue that decouples the front end from the back end.
module rxo_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  rxo_pkg::op_t data_i,
  output logic         full_o,
  input  logic         pop_i,
  output rxo_pkg::op_t data_o,
  output logic         empty_o
);
  import rxo_pkg::*;

  op_t                entry_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;

  assign full_o  = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/rxo_back.sv]
// Back end: command string store, rolling key, cursor and result register.
module rxo_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_valid_i,
  input  rxo_pkg::op_t               op_i,
  output logic                       op_pop_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [rxo_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       last_of_message_o
);
  import rxo_pkg::*;

  logic [BYTE_W-1:0] store_mem [STRING_DEPTH];
  logic [BYTE_W-1:0] cur_char_q;
  logic [BYTE_W-1:0] char0_q;

  logic [BYTE_W-1:0] key_q, key_d;
  logic [STR_AW-1:0] pos_q, pos_d;
  logic              parity_q, parity_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;

  logic              exec;
  logic              wr_en;
  logic [STR_AW-1:0] wr_idx;
  logic              cur_zero;
  logic [STR_AW-1:0] pos_base;
  logic [STR_AW-1:0] pos_next;
  logic [BYTE_W-1:0] char_raw;
  logic [BYTE_W-1:0] char_flt;
  logic [BYTE_W-1:0] char_sh;
  logic [BYTE_W-1:0] key_data;

  // Data ops wait for room in the result register; others go right through
  assign exec     = op_valid_i && ((op_i.kind != OP_DATA) || !out_valid_q || pop_i);
  assign op_pop_o = exec;

  // Store write, ignoring addresses past the end
  assign wr_idx = STR_AW'(op_i.addr);
  assign wr_en  = exec && (op_i.kind == OP_LOAD) && (32'(op_i.addr) < STRING_DEPTH);

  // Character fetch: cur_char_q holds the entry at the cursor, char0_q mirrors entry 0
  assign cur_zero = (cur_char_q == '0);
  assign char_raw = cur_zero ? char0_q : cur_char_q;
  assign char_flt = filter_char(char_raw);
  assign char_sh  = parity_q ? {char_flt[BYTE_W-2:0], 1'b0} : char_flt;
  assign key_data = key_q ^ char_sh;

  // Cursor advance, rewinding at the terminator and at the end of the store
  assign pos_base = cur_zero ? '0 : pos_q;
  assign pos_next = (pos_base == STR_AW'(STRING_DEPTH - 1)) ? '0 : pos_base + 1'b1;

  // Next-state logic
  always_comb begin
    key_d       = key_q;
    pos_d       = pos_q;
    parity_d    = parity_q;
    out_valid_d = out_valid_q && !pop_i;
    if (exec) begin
      case (op_i.kind)
        OP_START: begin
          key_d    = op_i.value;
          pos_d    = '0;
          parity_d = op_i.flag;
        end
        OP_DATA: begin
          key_d       = key_data;
          pos_d       = pos_next;
          parity_d    = !parity_q;
          out_valid_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      pos_q       <= '0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      key_q       <= key_d;
      pos_q       <= pos_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (exec && (op_i.kind == OP_DATA)) begin
      out_byte_q <= op_i.value ^ key_data;
      out_last_q <= op_i.flag;
    end
  end

  // String store with registered read at the next cursor, write data forwarded
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_idx] <= op_i.value;
    end
    if (wr_en && (wr_idx == pos_d)) begin
      cur_char_q <= op_i.value;
    end else begin
      cur_char_q <= store_mem[pos_d];
    end
    if (wr_en && (wr_idx == '0)) begin
      char0_q <= op_i.value;
    end
  end

  assign empty_o           = !out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign last_of_message_o = out_last_q;

endmodule

[hw/rtl/rolling_xor_packet_obfuscator.sv]
// Rolling-key XOR packet obfuscator: top level.
// A data item's result reaches the outputs through the op queue and then the result register.
// Throughput: one item per cycle, unless a data item waits for room in the result register.
// Load and start items produce no result and do not wait for room in the result register.
// Reset clears key, cursor, parity, challenge and both queues; the string store
// is not cleared and holds unknown data until loaded.
module rolling_xor_packet_obfuscator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rxo_pkg::WORD_W-1:0] cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  logic [rxo_pkg::FUNC_W-1:0] func_i,
  input  logic [rxo_pkg::ADDR_W-1:0] string_addr_i,
  input  logic [rxo_pkg::BYTE_W-1:0] string_byte_i,
  input  logic [rxo_pkg::WORD_W-1:0] seed_a_i,
  input  logic [rxo_pkg::WORD_W-1:0] seed_b_i,
  input  logic                       first_position_odd_i,
  input  logic [rxo_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       is_last_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [rxo_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       last_of_message_o
);
  import rxo_pkg::*;

  logic accept;
  logic op_push;
  op_t  op_in;
  op_t  op_out;
  logic op_empty;
  logic op_pop;

  assign accept = push && !full;

  rxo_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .func_i               (func_i),
    .string_addr_i        (string_addr_i),
    .string_byte_i        (string_byte_i),
    .seed_a_i             (seed_a_i),
    .seed_b_i             (seed_b_i),
    .first_position_odd_i (first_position_odd_i),
    .data_byte_i          (data_byte_i),
    .is_last_i            (is_last_i),
    .accept_i             (accept),
    .op_push_o            (op_push),
    .op_o                 (op_in)
  );

  rxo_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (op_pop),
    .data_o  (op_out),
    .empty_o (op_empty)
  );

  rxo_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_valid_i        (!op_empty),
    .op_i              (op_out),
    .op_pop_o          (op_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .out_byte_o        (out_byte_o),
    .last_of_message_o (last_of_message_o)
  );

endmodule

[hw/rtl/rxo_checker.sv]
// Port-level checker for the obfuscator, bound to the top level.
module rxo_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [rxo_pkg::BYTE_W-1:0] out_byte_o,
  input logic                       last_of_message_o
);
  import rxo_pkg::*;

  // Both sides come out of reset with nothing queued
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not clear after reset");

  // The input queue only fills up through an input transfer
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !$past(full)) |-> $past(push))
    else $error("full rose without an input transfer");

  // A waiting result holds until it is taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_of_message_o)))
    else $error("stalled result changed");

  // A result cannot appear without an earlier input transfer
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !(push && !full)) |=> ##1 (!$fell(empty) || $past(push, 2) ||
      $past(push, 3) || $past(!empty, 1) || $past(full, 2) || $past(full, 3) ||
      !$past(rst_ni, 3)))
    else $error("result appeared without a prior input transfer");

endmodule

bind rolling_xor_packet_obfuscator rxo_checker u_rxo_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .push              (push),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_byte_o        (out_byte_o),
  .last_of_message_o (last_of_message_o)
);
